// ===== rtl/core/mts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the min-tracking stack unit.
// ----------------------------------------------------------------------------
package mts_pkg;

   // Operation codes carried in the request word.
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Least 32-bit signed integer, reported for an empty stack.
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

   // Request word.
   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] push_value;
   } req_type;

   // Response word.
   typedef struct packed {
      logic signed [31:0] top_value;
      logic signed [31:0] min_value;
      logic               is_empty;
      logic               overflow;
      logic [6:0]         entry_count;
   } rsp_type;

   // One stack entry: the value and the minimum at and below it.
   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] minimum;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // capture the request and apply the push or pop
      logic finish;   // refill the top cache and build the response
   } dp_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/core/min_tracking_stack_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack_unit
// Sequence: a word is accepted while idle, the finish step runs in the load
// state, and the response and its strobe are registered from that step.
// No new word is accepted while busy in the finish step, which waits for the
// registered read of the entry memory that refreshes the cached top after a pop.
// The receiver cannot stall; each response is shown for exactly one cycle.
// Reset empties the stack at once; no clearing pass runs over the memory.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mts_pkg::req_type req_data,
   output logic                  rsp_valid,
   output mts_pkg::rsp_type      rsp_data
);

   mts_pkg::dp_cmd_type cmd;

   // Sequencing of each word.
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Stack storage and response formation.
   mts_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/core/mts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_ctrl
// Controller: sequences each request through accept and finish steps and
// drives the busy flag and the response strobe.
// ----------------------------------------------------------------------------
module mts_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output logic                    rsp_valid,
   output mts_pkg::dp_cmd_type     cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      strobe_in = cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy      = (state_ff == ST_LOAD);
   assign rsp_valid = strobe_ff;

   // An accepted word always reaches the finish step on the next cycle.
   a_accept_then_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.finish)
      else $error("accept not followed by finish");

   // The response strobe comes in the cycle after the finish step.
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(cmd.finish))
      else $error("response strobe out of step with finish");

   // Accept and finish never coincide.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.finish))
      else $error("accept and finish in the same cycle");

endmodule
`default_nettype wire

// ===== rtl/core/mts_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_dpath
// Datapath: entry memory, fill count, cached top entry and response register.
// ----------------------------------------------------------------------------
module mts_dpath #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mts_pkg::dp_cmd_type cmd,
   input  wire mts_pkg::req_type    req_data,
   output mts_pkg::rsp_type         rsp_data
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   // Entry memory, one entry per stack level.
   mts_pkg::entry_type entry_mem [STACK_DEPTH];

   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] top_ff, top_in;
   logic signed [31:0] min_ff, min_in;
   logic               fill_ff, fill_in;
   logic               ovf_ff, ovf_in;
   mts_pkg::entry_type rd_data_ff;
   mts_pkg::rsp_type   rsp_ff, rsp_in;

   logic               is_push, is_pop, full, empty;
   logic signed [31:0] push_min;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [CW-1:0]      count_m2;
   logic signed [31:0] top_now, min_now;

   // Decode of the request and the new entry's running minimum.
   always_comb begin
      full     = (count_ff == FULL_COUNT);
      empty    = (count_ff == '0);
      is_push  = (req_data.operation == mts_pkg::OP_PUSH);
      is_pop   = (req_data.operation == mts_pkg::OP_POP);
      push_min = (empty || (req_data.push_value < min_ff)) ? req_data.push_value : min_ff;
      wr_addr  = count_ff[AW-1:0];
      count_m2 = count_ff - CW'(2);
      rd_addr  = count_m2[AW-1:0];
   end

   // State update for accept (push or pop) and finish (refill after pop).
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      min_in   = min_ff;
      fill_in  = fill_ff;
      ovf_in   = ovf_ff;
      top_now  = fill_ff ? rd_data_ff.value : top_ff;
      min_now  = fill_ff ? rd_data_ff.minimum : min_ff;
      if (cmd.accept) begin
         fill_in = 1'b0;
         ovf_in  = 1'b0;
         if (is_push) begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + CW'(1);
               top_in   = req_data.push_value;
               min_in   = push_min;
            end
         end else if (is_pop && !empty) begin
            count_in = count_ff - CW'(1);
            fill_in  = 1'b1;
         end
      end else if (cmd.finish) begin
         top_in  = top_now;
         min_in  = min_now;
         fill_in = 1'b0;
      end
   end

   // Response built from the refreshed top entry.
   always_comb begin
      rsp_in             = rsp_ff;
      if (cmd.finish) begin
         rsp_in.is_empty    = empty;
         rsp_in.overflow    = ovf_ff;
         rsp_in.entry_count = 7'(count_ff);
         rsp_in.top_value   = empty ? mts_pkg::INT_MIN : top_now;
         rsp_in.min_value   = empty ? mts_pkg::INT_MIN : min_now;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      min_ff <= min_in;
      rsp_ff <= rsp_in;
   end

   // Entry memory: write on push, registered read of the entry below the top.
   always_ff @(posedge clock) begin
      if (cmd.accept && is_push && !full) begin
         entry_mem[wr_addr] <= '{value: req_data.push_value, minimum: push_min};
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rsp_data = rsp_ff;

   // The fill count never passes the stack depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count above stack depth");

   // A dropped push leaves the count unchanged and the stack full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && is_push && full) |=> (ovf_ff && count_ff == FULL_COUNT))
      else $error("dropped push changed the stack");

   // A refill is only pending right after a pop that removed an entry.
   a_fill_after_pop: assert property (@(posedge clock) disable iff (reset)
      fill_ff |-> ($past(cmd.accept) && $past(count_ff) == count_ff + CW'(1)))
      else $error("refill without a pop");

endmodule
`default_nettype wire

// ===== verif/tb_min_tracking_stack_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_tracking_stack_unit
// Self-checking bench for the min-tracking stack. A queue of command words
// is built up front: a directed opening over empty, equal and extreme
// values, then random fill, drain and mixed sequences that reach a full
// stack and dropped pushes. A driver offers the words with random gaps, a
// monitor predicts the status word for every accepted command and compares
// each response strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_min_tracking_stack_unit;

   localparam int DEPTH       = 64;
   localparam int ITEM_TARGET = 880;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, behaves as a query

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   mts_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   mts_pkg::rsp_type rsp_data;

   // Command words waiting to be offered and status words still owed.
   mts_pkg::req_type op_words[$];
   mts_pkg::rsp_type status_owed[$];

   int  cycle_count    = 0;
   int  mismatch_count = 0;
   bit  offer_open     = 1'b0;
   int  gap_left       = 0;
   int  calm_left      = 0;
   int  plan_fill      = 0;

   // Predicted stack contents.
   logic signed [31:0] value_model[DEPTH];
   logic signed [31:0] minimum_model[DEPTH];
   int                 model_fill = 0;

   min_tracking_stack_unit #(
      .STACK_DEPTH(DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Applies one command to the predicted stack and returns the status word.
   function automatic mts_pkg::rsp_type stack_status_after(input mts_pkg::req_type w);
      mts_pkg::rsp_type   status;
      logic signed [31:0] pushed;
      logic signed [31:0] below;
      logic signed [31:0] running_min;
      status = '0;
      pushed = w.push_value;
      case (w.operation)
         mts_pkg::OP_PUSH: begin
            if (model_fill >= DEPTH) begin
               status.overflow = 1'b1;
            end else begin
               running_min = pushed;
               if (model_fill > 0) begin
                  below = minimum_model[model_fill - 1];
                  // An equal value keeps the minimum already recorded.
                  if (!(pushed < below)) running_min = below;
               end
               value_model[model_fill]   = pushed;
               minimum_model[model_fill] = running_min;
               model_fill++;
            end
         end
         mts_pkg::OP_POP: begin
            if (model_fill > 0) model_fill--;
         end
         default: ;
      endcase
      if (model_fill == 0) begin
         status.top_value = mts_pkg::INT_MIN;
         status.min_value = mts_pkg::INT_MIN;
         status.is_empty  = 1'b1;
      end else begin
         status.top_value = value_model[model_fill - 1];
         status.min_value = minimum_model[model_fill - 1];
      end
      status.entry_count = 7'(model_fill);
      return status;
   endfunction

   // Value mix: full range, a narrow band for repeats, and the extremes.
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom;
      if (r < 85) return 32'($signed($urandom_range(16)) - 8);
      case ($urandom_range(3))
         0:       return mts_pkg::INT_MIN;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   // Mostly short gaps, a few long ones, and calm stretches with none.
   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(99) < 3) begin
         calm_left = $urandom_range(80, 30);
         return 0;
      end
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic add_word(input logic [1:0] op, input logic signed [31:0] value);
      mts_pkg::req_type w;
      w.operation  = op;
      w.push_value = value;
      op_words.push_back(w);
      if (op == mts_pkg::OP_PUSH && plan_fill < DEPTH) plan_fill++;
      if (op == mts_pkg::OP_POP && plan_fill > 0) plan_fill--;
   endtask

   // Opens with queries and pops on an empty stack and the unused code,
   // then extremes and equal values, then a full drain with one pop too many.
   task automatic add_directed_words();
      add_word(mts_pkg::OP_QUERY, 32'sd0);
      add_word(mts_pkg::OP_POP, 32'sh7fff_ffff);
      add_word(OP_SPARE, -32'sd1);
      add_word(mts_pkg::OP_PUSH, 32'sd5);
      add_word(mts_pkg::OP_PUSH, 32'sd5);
      add_word(mts_pkg::OP_PUSH, 32'sd7);
      add_word(mts_pkg::OP_PUSH, -32'sd3);
      add_word(mts_pkg::OP_PUSH, 32'sh7fff_ffff);
      add_word(mts_pkg::OP_PUSH, mts_pkg::INT_MIN);
      add_word(mts_pkg::OP_QUERY, 32'sd1);
      add_word(mts_pkg::OP_PUSH, mts_pkg::INT_MIN);
      add_word(mts_pkg::OP_PUSH, 32'sd0);
      add_word(OP_SPARE, mts_pkg::INT_MIN);
      repeat (8) add_word(mts_pkg::OP_POP, $urandom);
      add_word(mts_pkg::OP_POP, 32'sd0);
      add_word(mts_pkg::OP_QUERY, -32'sd1);
   endtask

   // Random sequences: fills that run into dropped pushes, drains that run
   // past empty, and mixed stretches of every code.
   task automatic add_random_words();
      int kind;
      int r;
      while (op_words.size() < ITEM_TARGET) begin
         kind = $urandom_range(9);
         if (kind < 3) begin
            while (plan_fill < DEPTH) begin
               if ($urandom_range(9) == 0) add_word(mts_pkg::OP_QUERY, $urandom);
               else add_word(mts_pkg::OP_PUSH, pick_value());
            end
            repeat ($urandom_range(4, 1)) add_word(mts_pkg::OP_PUSH, pick_value());
         end else if (kind < 5) begin
            while (plan_fill > 0) begin
               if ($urandom_range(9) == 0) add_word(mts_pkg::OP_QUERY, $urandom);
               else add_word(mts_pkg::OP_POP, $urandom);
            end
            repeat ($urandom_range(2, 1)) add_word(mts_pkg::OP_POP, $urandom);
         end else begin
            repeat ($urandom_range(60, 20)) begin
               r = $urandom_range(99);
               if (r < 45) add_word(mts_pkg::OP_PUSH, pick_value());
               else if (r < 80) add_word(mts_pkg::OP_POP, $urandom);
               else if (r < 95) add_word(mts_pkg::OP_QUERY, $urandom);
               else add_word(OP_SPARE, $urandom);
            end
         end
      end
   endtask

   // Driver: hold reset, then offer words at the falling edge.
   always @(negedge clock) begin
      reset <= (cycle_count < 9);
      if (cycle_count >= 10 && !offer_open) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (op_words.size() != 0) begin
            start      <= 1'b1;
            req_data   <= op_words[0];
            offer_open  = 1'b1;
            gap_left    = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predict on every accepted word, check every response strobe.
   always @(posedge clock) begin
      mts_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy && offer_open) begin
            status_owed.push_back(stack_status_after(req_data));
            void'(op_words.pop_front());
            offer_open = 1'b0;
         end
         if (rsp_valid) begin
            if (status_owed.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = status_owed.pop_front();
               if (rsp_data.top_value !== want.top_value) begin
                  mismatch_count++;
                  $display("%0t: top_value expected %h actual %h",
                           $time, want.top_value, rsp_data.top_value);
               end
               if (rsp_data.min_value !== want.min_value) begin
                  mismatch_count++;
                  $display("%0t: min_value expected %h actual %h",
                           $time, want.min_value, rsp_data.min_value);
               end
               if (rsp_data.is_empty !== want.is_empty) begin
                  mismatch_count++;
                  $display("%0t: is_empty expected %b actual %b",
                           $time, want.is_empty, rsp_data.is_empty);
               end
               if (rsp_data.overflow !== want.overflow) begin
                  mismatch_count++;
                  $display("%0t: overflow expected %b actual %b",
                           $time, want.overflow, rsp_data.overflow);
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  mismatch_count++;
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, want.entry_count, rsp_data.entry_count);
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Build the stimulus, then wait for every word and response to settle.
   initial begin
      add_directed_words();
      add_random_words();
      do @(posedge clock);
      while (op_words.size() != 0 || offer_open || status_owed.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && status_owed.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
